/* rtl/core/i2cm_pkg.sv */
// Shared types and codes for the I2C master bit sequencer.
`default_nettype none

package i2cm_pkg;

  localparam int unsigned HalfBitW = 16;
  localparam logic [HalfBitW-1:0] HalfBitTicksRst = 16'd10;

  localparam logic [1:0] MODE_START = 2'd0;
  localparam logic [1:0] MODE_STOP  = 2'd1;
  localparam logic [1:0] MODE_WRITE = 2'd2;
  localparam logic [1:0] MODE_READ  = 2'd3;

  localparam logic [3:0] PH_IDLE   = 4'd0;
  localparam logic [3:0] PH_ST1    = 4'd1;
  localparam logic [3:0] PH_ST2    = 4'd2;
  localparam logic [3:0] PH_ST3    = 4'd3;
  localparam logic [3:0] PH_SP1    = 4'd4;
  localparam logic [3:0] PH_SP2    = 4'd5;
  localparam logic [3:0] PH_SP3    = 4'd6;
  localparam logic [3:0] PH_WR_HI  = 4'd7;
  localparam logic [3:0] PH_WR_LO  = 4'd8;
  localparam logic [3:0] PH_WR_AHI = 4'd9;
  localparam logic [3:0] PH_WR_END = 4'd10;
  localparam logic [3:0] PH_RD_HI  = 4'd11;
  localparam logic [3:0] PH_RD_LO  = 4'd12;
  localparam logic [3:0] PH_RD_AHI = 4'd13;
  localparam logic [3:0] PH_RD_END = 4'd14;

  localparam logic [3:0] BitsPerByte = 4'd8;

  typedef struct packed {
    logic       cmd_valid;
    logic [1:0] mode;
    logic [7:0] tx_byte;
    logic       ack_level;
    logic       sda_in;
  } tick_req_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       sda_enable;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_seen;
  } tick_rsp_t;

endpackage

`default_nettype wire

/* rtl/core/i2cm_step.sv */
// Bus sequencer state and the per-tick next-state logic.
`default_nettype none

module i2cm_step import i2cm_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                step_i,
  input  wire tick_req_t           req_i,
  input  wire logic [HalfBitW-1:0] half_bit_ticks_i,
  output tick_rsp_t                rsp_o
);

  logic [3:0]          phase_q, phase_d;
  logic [3:0]          bit_count_q, bit_count_d;
  logic [7:0]          shift_q, shift_d;
  logic [HalfBitW-1:0] wait_q, wait_d;
  logic                ack_latch_q, ack_latch_d;
  logic                held_ack_q, held_ack_d;
  logic                scl_q, scl_d;
  logic                sda_q, sda_d;
  logic                en_q, en_d;
  logic [7:0]          rx_hold_q, rx_hold_d;
  logic                fin;
  logic                done;
  logic [HalfBitW-1:0] arm_ticks;

  assign arm_ticks = (half_bit_ticks_i == '0) ? HalfBitW'(1) : half_bit_ticks_i;

  always_comb begin
    phase_d     = phase_q;
    bit_count_d = bit_count_q;
    shift_d     = shift_q;
    wait_d      = wait_q;
    ack_latch_d = ack_latch_q;
    held_ack_d  = held_ack_q;
    scl_d       = scl_q;
    sda_d       = sda_q;
    en_d        = en_q;
    rx_hold_d   = rx_hold_q;
    fin         = 1'b0;
    done        = 1'b0;
    if (step_i) begin
      priority if (phase_q == PH_IDLE) begin
        if (req_i.cmd_valid) begin
          bit_count_d = 4'd0;
          unique case (req_i.mode)
            MODE_START: begin
              scl_d   = 1'b1;
              sda_d   = 1'b1;
              en_d    = 1'b1;
              phase_d = PH_ST1;
            end
            MODE_STOP: begin
              en_d    = 1'b1;
              sda_d   = 1'b0;
              phase_d = PH_SP1;
            end
            MODE_WRITE: begin
              en_d        = 1'b1;
              sda_d       = req_i.tx_byte[7];
              shift_d     = {req_i.tx_byte[6:0], 1'b0};
              bit_count_d = 4'd1;
              phase_d     = PH_WR_HI;
            end
            default: begin
              en_d       = 1'b0;
              shift_d    = 8'd0;
              held_ack_d = req_i.ack_level;
              phase_d    = PH_RD_HI;
            end
          endcase
          wait_d = arm_ticks;
        end
      end else if (wait_q > HalfBitW'(1)) begin
        wait_d = wait_q - HalfBitW'(1);
      end else begin
        unique case (phase_q)
          PH_ST1: begin
            sda_d   = 1'b0;
            phase_d = PH_ST2;
          end
          PH_ST2: begin
            scl_d   = 1'b0;
            phase_d = PH_ST3;
          end
          PH_ST3: fin = 1'b1;
          PH_SP1: begin
            scl_d   = 1'b1;
            phase_d = PH_SP2;
          end
          PH_SP2: begin
            sda_d   = 1'b1;
            phase_d = PH_SP3;
          end
          PH_SP3: begin
            en_d = 1'b0;
            fin  = 1'b1;
          end
          PH_WR_HI: begin
            scl_d   = 1'b1;
            phase_d = PH_WR_LO;
          end
          PH_WR_LO: begin
            scl_d = 1'b0;
            if (bit_count_q < BitsPerByte) begin
              sda_d       = shift_q[7];
              shift_d     = {shift_q[6:0], 1'b0};
              bit_count_d = bit_count_q + 4'd1;
              phase_d     = PH_WR_HI;
            end else begin
              en_d    = 1'b0;
              phase_d = PH_WR_AHI;
            end
          end
          PH_WR_AHI: begin
            scl_d       = 1'b1;
            ack_latch_d = req_i.sda_in;
            phase_d     = PH_WR_END;
          end
          PH_WR_END: begin
            scl_d = 1'b0;
            fin   = 1'b1;
          end
          PH_RD_HI: begin
            scl_d       = 1'b1;
            shift_d     = {shift_q[6:0], req_i.sda_in};
            bit_count_d = bit_count_q + 4'd1;
            phase_d     = PH_RD_LO;
          end
          PH_RD_LO: begin
            scl_d = 1'b0;
            if (bit_count_q < BitsPerByte) begin
              phase_d = PH_RD_HI;
            end else begin
              en_d    = 1'b1;
              sda_d   = held_ack_q;
              phase_d = PH_RD_AHI;
            end
          end
          PH_RD_AHI: begin
            scl_d   = 1'b1;
            phase_d = PH_RD_END;
          end
          PH_RD_END: begin
            scl_d     = 1'b0;
            en_d      = 1'b0;
            rx_hold_d = shift_q;
            fin       = 1'b1;
          end
          default: fin = 1'b1;
        endcase
        if (fin) begin
          phase_d = PH_IDLE;
          wait_d  = '0;
        end else begin
          wait_d = arm_ticks;
        end
        done = fin;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      bit_count_q <= 4'd0;
      shift_q     <= 8'd0;
      wait_q      <= '0;
      ack_latch_q <= 1'b0;
      held_ack_q  <= 1'b1;
      scl_q       <= 1'b1;
      sda_q       <= 1'b1;
      en_q        <= 1'b0;
      rx_hold_q   <= 8'd0;
    end else begin
      phase_q     <= phase_d;
      bit_count_q <= bit_count_d;
      shift_q     <= shift_d;
      wait_q      <= wait_d;
      ack_latch_q <= ack_latch_d;
      held_ack_q  <= held_ack_d;
      scl_q       <= scl_d;
      sda_q       <= sda_d;
      en_q        <= en_d;
      rx_hold_q   <= rx_hold_d;
    end
  end

  always_comb begin
    rsp_o.scl_out    = scl_d;
    rsp_o.sda_out    = sda_d;
    rsp_o.sda_enable = en_d;
    rsp_o.busy_res   = (phase_d != PH_IDLE);
    rsp_o.done_res   = done;
    rsp_o.rx_byte    = rx_hold_d;
    rsp_o.ack_seen   = ack_latch_d;
  end

endmodule

`default_nettype wire

/* rtl/core/i2c_master_bit_sequencer.sv */
// Top level of the tick-driven I2C master bit sequencer.
`default_nettype none

// Each request is one tick of bus timing and yields exactly one response carrying the
// SCL and SDA line levels, SDA drive enable, busy and done flags, the last received
// byte and the last write ack. A request is registered on acceptance, stepped through
// the sequencer when the output can accept it, and its response is held in an output
// register, so one request is taken per cycle unless the output stalls. The edge
// spacing register is written through cfg_we_i while the bus is idle, which the user
// must ensure as the block does not enforce it; a value of zero acts as one tick.

module i2c_master_bit_sequencer import i2cm_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire tick_req_t           in_req_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output tick_rsp_t                out_rsp_o,
  input  wire logic                cfg_we_i,
  input  wire logic [HalfBitW-1:0] cfg_wdata_i
);

  logic                in_valid_q;
  tick_req_t           in_req_q;
  logic                out_valid_q;
  tick_rsp_t           out_rsp_q;
  logic [HalfBitW-1:0] half_bit_q;
  logic                out_ready;
  logic                step;
  tick_rsp_t           step_rsp;

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign step       = in_valid_q && out_ready;
  assign in_stall_o = in_valid_q && !out_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_bit_q <= HalfBitTicksRst;
    end else if (cfg_we_i) begin
      half_bit_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_valid_i && !in_stall_o) begin
      in_valid_q <= 1'b1;
    end else if (step) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_req_q <= in_req_i;
    end
  end

  i2cm_step u_step (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_i          (step),
    .req_i           (in_req_q),
    .half_bit_ticks_i(half_bit_q),
    .rsp_o           (step_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= step;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_rsp_q <= step_rsp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule

`default_nettype wire
